// ===== rtl/cti_pkg.sv =====
// ----------------------------------------------------------------------------
// cti_pkg
// Shared widths, constants, codes and types of the cone track isolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package cti_pkg;

  // field widths
  localparam int ETA_W      = 16;
  localparam int PHI_W      = 15;
  localparam int PT_W       = 20;
  localparam int Z_W        = 20;
  localparam int RAD_W      = 14;
  localparam int GAP_W      = 19;
  localparam int ACC_W      = 32;
  localparam int RATIO_W    = 24;
  localparam int DIST_W     = 28;
  localparam int SQ_W       = 16;
  localparam int PROD_W     = 2 * SQ_W;
  localparam int DSUM_W     = PROD_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int DIV_CNT_W  = $clog2(RATIO_W);

  // angle scaling
  localparam int ANGLE_FRAC_BITS = 12;
  localparam longint unsigned PI_Q32 = 64'd13493037705;
  localparam longint unsigned PI_ROUND =
      (PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
  localparam int DP_W = 20;
  localparam logic signed [DP_W-1:0] PI_FIX     = DP_W'(PI_ROUND);
  localparam logic signed [DP_W-1:0] TWO_PI_FIX = DP_W'(2 * PI_ROUND);

  // reset values
  localparam logic [RAD_W-1:0]  MIN_RADIUS_RST = RAD_W'(41);
  localparam logic [GAP_W-1:0]  MAX_Z_GAP_RST  = GAP_W'(512);
  localparam logic [GAP_W-1:0]  MAX_IMPACT_RST = GAP_W'(205);
  localparam logic [DIST_W-1:0] DIST_NONE      = '1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TRACK = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RADIUS = 2'd0,
    REG_MAX_Z_GAP  = 2'd1,
    REG_MAX_IMPACT = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DE,
    ST_WRAP,
    ST_ADD,
    ST_RAD,
    ST_MIN,
    ST_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT
  } cti_state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] total;
    logic [PT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [RATIO_W-1:0] ratio;
    logic [ACC_W-1:0]   pt_total;
    logic               zero_pt;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/cti_in_if.sv =====
// ----------------------------------------------------------------------------
// cti_in_if
// Input channel: start and track words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cti_in_if import cti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [ETA_W-1:0] eta;
  logic signed [PHI_W-1:0] phi;
  logic [PT_W-1:0]         pt;
  logic signed [Z_W-1:0]   z_pos;
  logic signed [Z_W-1:0]   impact;
  logic signed [ETA_W-1:0] second_eta;
  logic signed [PHI_W-1:0] second_phi;
  logic                    has_second;
  logic [RAD_W-1:0]        cone_radius;
  logic                    last;

  modport source (
    output valid, opcode, eta, phi, pt, z_pos, impact, second_eta, second_phi,
           has_second, cone_radius, last,
    input  ready
  );
  modport sink (
    input  valid, opcode, eta, phi, pt, z_pos, impact, second_eta, second_phi,
           has_second, cone_radius, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/cti_out_if.sv =====
// ----------------------------------------------------------------------------
// cti_out_if
// Result channel: isolation ratio words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cti_out_if import cti_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] iso_ratio;
  logic [ACC_W-1:0]   pt_total;
  logic               zero_pt;

  modport source (output valid, iso_ratio, pt_total, zero_pt, input ready);
  modport sink   (input valid, iso_ratio, pt_total, zero_pt, output ready);
endinterface

`default_nettype wire

// ===== rtl/cti_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cti_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cti_cfg_if import cti_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cone_track_isolation.sv =====
// ----------------------------------------------------------------------------
// cone_track_isolation
// Track pt sum in a cone around a muon, second muon removal, pt ratio.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | word
//  in_ch    | in  | valid/ready  | opcode, angles, pt, z, impact, 2nd muon, cone
//  out_ch   | out | valid/ready  | iso_ratio, pt_total, zero_pt
//  cfg_ch   | in  | valid/ready  | idx, data (always ready)
//
//  A track word runs DE, WRAP, ADD for the reference and again for the second
//  muon, WRAP repeating per extra phi wrap step, then RAD, MIN, UPD; one 16x16
//  squarer is shared by all distance and radius terms. A last word then starts
//  the bit-serial divider, bypassed for a zero muon pt or a saturated ratio.
//  in_ch.ready is high only when the sequencer is idle; a result waiting on
//  out_ch does not block new words until the next result is due.
//  rst_n loads the register defaults and clears the reference and sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cone_track_isolation import cti_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cti_in_if.sink    in_ch,
  cti_out_if.source out_ch,
  cti_cfg_if.sink   cfg_ch
);

  cti_state_t state_r, state_nxt;

  // configuration
  logic [RAD_W-1:0] min_rad_r;
  logic [GAP_W-1:0] max_z_gap_r;
  logic [GAP_W-1:0] max_impact_r;

  // reference
  logic signed [ETA_W-1:0] ref_eta_r, oth_eta_r;
  logic signed [PHI_W-1:0] ref_phi_r, oth_phi_r;
  logic [PT_W-1:0]         ref_pt_r;
  logic signed [Z_W-1:0]   vtx_z_r;
  logic                    oth_present_r;
  logic [RAD_W-1:0]        outer_rad_r;

  // sums
  logic [ACC_W-1:0]  acc_r;
  logic [PT_W-1:0]   near_pt_r;
  logic [DIST_W-1:0] near_dist_r;

  // track word
  logic signed [ETA_W-1:0] tr_eta_r;
  logic signed [PHI_W-1:0] tr_phi_r;
  logic [PT_W-1:0]         tr_pt_r;
  logic signed [Z_W-1:0]   tr_z_r;
  logic signed [Z_W-1:0]   tr_imp_r;
  logic                    last_r;

  // shared squarer datapath
  logic                    ctr_r;
  logic signed [DP_W-1:0]  dp_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DSUM_W-1:0]       dsum_r;
  logic [DSUM_W-1:0]       d2_r;
  logic [DSUM_W-1:0]       d2o_r;
  logic [DIST_W-1:0]       rad2_r;

  // result register
  logic               out_valid_r;
  logic [RATIO_W-1:0] out_ratio_r;
  logic [ACC_W-1:0]   out_total_r;
  logic               out_zero_r;

  logic in_fire, in_ready, out_load, div_start;
  logic start_fire, track_fire;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------- operand selection ----------------
  logic signed [ETA_W:0] de;
  logic [ETA_W:0]        de_neg;
  logic [SQ_W-1:0]       de_abs;
  logic signed [DP_W-1:0] dp_init;
  logic [DP_W-1:0]       dp_neg;
  logic [SQ_W-1:0]       dp_abs;
  logic                  dp_hi, dp_lo;
  logic [SQ_W-1:0]       mul_a;
  logic [PROD_W-1:0]     prod_c;
  logic [DSUM_W-1:0]     dist_sum;

  assign de = {tr_eta_r[ETA_W-1], tr_eta_r}
            - (ctr_r ? {oth_eta_r[ETA_W-1], oth_eta_r} : {ref_eta_r[ETA_W-1], ref_eta_r});
  assign de_neg = -de;
  assign de_abs = de[ETA_W] ? de_neg[SQ_W-1:0] : de[SQ_W-1:0];

  assign dp_init = DP_W'(tr_phi_r) - (ctr_r ? DP_W'(oth_phi_r) : DP_W'(ref_phi_r));
  assign dp_hi   = (dp_r > PI_FIX);
  assign dp_lo   = (dp_r <= -PI_FIX);
  assign dp_neg  = -dp_r;
  assign dp_abs  = dp_r[DP_W-1] ? dp_neg[SQ_W-1:0] : dp_r[SQ_W-1:0];

  always_comb begin
    case (state_r)
      ST_DE:   mul_a = de_abs;
      ST_WRAP: mul_a = dp_abs;
      ST_RAD:  mul_a = SQ_W'(outer_rad_r);
      ST_MIN:  mul_a = SQ_W'(min_rad_r);
      default: mul_a = '0;
    endcase
  end

  assign prod_c   = {{SQ_W{1'b0}}, mul_a} * {{SQ_W{1'b0}}, mul_a};
  assign dist_sum = dsum_r + {1'b0, prod_r};

  // ---------------- track decision ----------------
  logic signed [Z_W:0] dz;
  logic [Z_W:0]        dz_neg;
  logic [Z_W:0]        adz;
  logic                ok_z, ok_imp, pass, near_hit;
  logic [DIST_W-1:0]   min2;
  logic [ACC_W:0]      acc_sum;
  logic [ACC_W-1:0]    acc_sat;

  assign dz     = {tr_z_r[Z_W-1], tr_z_r} - {vtx_z_r[Z_W-1], vtx_z_r};
  assign dz_neg = -dz;
  assign adz    = dz[Z_W] ? dz_neg : dz;
  assign ok_z   = (adz <= (Z_W+1)'(max_z_gap_r));
  assign ok_imp = (tr_imp_r <= $signed({1'b0, max_impact_r}));
  assign min2   = prod_r[DIST_W-1:0];
  assign pass   = (d2_r <= DSUM_W'(rad2_r)) && (d2_r >= DSUM_W'(min2)) && ok_z && ok_imp;
  assign near_hit = oth_present_r && (d2o_r < DSUM_W'(min2))
                 && (d2o_r < DSUM_W'(near_dist_r));
  assign acc_sum = {1'b0, acc_r} + (ACC_W+1)'(tr_pt_r);
  assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  // ---------------- sequencer ----------------
  assign in_fire    = in_ch.valid && in_ready;
  assign start_fire = in_fire && (in_ch.opcode == OP_START);
  assign track_fire = in_fire && (in_ch.opcode == OP_TRACK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.opcode == OP_TRACK) begin
            state_nxt = ST_DE;
          end else if (in_ch.last) begin
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_DE:   state_nxt = ST_WRAP;
      ST_WRAP: begin
        if (!dp_hi && !dp_lo) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD:  state_nxt = ctr_r ? ST_RAD : ST_DE;
      ST_RAD:  state_nxt = ST_MIN;
      ST_MIN:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = last_r ? ST_DIV_GO : ST_IDLE;
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_rsp.busy && (!out_valid_r || out_ch.ready)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rad_r    <= MIN_RADIUS_RST;
      max_z_gap_r  <= MAX_Z_GAP_RST;
      max_impact_r <= MAX_IMPACT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.idx))
        REG_MIN_RADIUS: min_rad_r    <= cfg_ch.data[RAD_W-1:0];
        REG_MAX_Z_GAP:  max_z_gap_r  <= cfg_ch.data[GAP_W-1:0];
        REG_MAX_IMPACT: max_impact_r <= cfg_ch.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- reference and sums ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_eta_r     <= '0;
      ref_phi_r     <= '0;
      ref_pt_r      <= '0;
      vtx_z_r       <= '0;
      oth_eta_r     <= '0;
      oth_phi_r     <= '0;
      oth_present_r <= 1'b0;
      outer_rad_r   <= '0;
      acc_r         <= '0;
      near_pt_r     <= '0;
      near_dist_r   <= DIST_NONE;
    end else if (start_fire) begin
      ref_eta_r     <= in_ch.eta;
      ref_phi_r     <= in_ch.phi;
      ref_pt_r      <= in_ch.pt;
      vtx_z_r       <= in_ch.z_pos;
      oth_eta_r     <= in_ch.second_eta;
      oth_phi_r     <= in_ch.second_phi;
      oth_present_r <= in_ch.has_second;
      outer_rad_r   <= in_ch.cone_radius;
      acc_r         <= '0;
      near_pt_r     <= '0;
      near_dist_r   <= DIST_NONE;
    end else if (state_r == ST_UPD && pass) begin
      acc_r <= acc_sat;
      if (near_hit) begin
        near_pt_r   <= tr_pt_r;
        near_dist_r <= d2o_r[DIST_W-1:0];
      end
    end else if (div_start) begin
      acc_r       <= '0;
      near_pt_r   <= '0;
      near_dist_r <= DIST_NONE;
    end
  end

  // ---------------- track word and distance datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= 1'b0;
    end else if (track_fire) begin
      ctr_r <= 1'b0;
    end else if (state_r == ST_ADD) begin
      ctr_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (track_fire) begin
      tr_eta_r <= in_ch.eta;
      tr_phi_r <= in_ch.phi;
      tr_pt_r  <= in_ch.pt;
      tr_z_r   <= in_ch.z_pos;
      tr_imp_r <= in_ch.impact;
      last_r   <= in_ch.last;
    end
    case (state_r)
      ST_DE: begin
        prod_r <= prod_c;
        dp_r   <= dp_init;
      end
      ST_WRAP: begin
        // prod_r holds the eta term until phi is in range
        dsum_r <= {1'b0, prod_r};
        if (dp_hi) begin
          dp_r <= dp_r - TWO_PI_FIX;
        end else if (dp_lo) begin
          dp_r <= dp_r + TWO_PI_FIX;
        end else begin
          prod_r <= prod_c;
        end
      end
      ST_ADD: begin
        if (ctr_r) begin
          d2o_r <= dist_sum;
        end else begin
          d2_r <= dist_sum;
        end
      end
      ST_RAD: prod_r <= prod_c;
      ST_MIN: begin
        rad2_r <= prod_r[DIST_W-1:0];
        prod_r <= prod_c;
      end
      default: ;
    endcase
  end

  // ---------------- divider ----------------
  assign div_req.start   = div_start;
  assign div_req.total   = acc_r - ACC_W'(near_pt_r);
  assign div_req.divisor = ref_pt_r;

  cti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ratio_r <= div_rsp.ratio;
      out_total_r <= div_rsp.pt_total;
      out_zero_r  <= div_rsp.zero_pt;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.iso_ratio = out_ratio_r;
  assign out_ch.pt_total  = out_total_r;
  assign out_ch.zero_pt   = out_zero_r;

endmodule

`default_nettype wire

// ===== rtl/cti_div.sv =====
// ----------------------------------------------------------------------------
// cti_div
// Restoring divider: (total << 16) / divisor, one quotient bit per cycle,
// saturated to the ratio width, zero divisor flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_div import cti_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PT_W-1:0]      dvs_r;
  logic [PT_W-1:0]      rem_r;
  logic [RATIO_W-1:0]   num_r;
  logic [RATIO_W-1:0]   quo_r;
  logic [ACC_W-1:0]     total_r;
  logic                 zero_r;

  logic [PT_W:0]        trial;
  logic [PT_W:0]        diff;
  logic                 qbit;
  logic                 sat;

  assign trial = {rem_r, num_r[RATIO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});
  // quotient reaches 2^24 exactly when total >= divisor * 2^8
  assign sat   = (req.total >= {4'b0, req.divisor, 8'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      cnt_r  <= '0;
      busy_r <= (req.divisor != '0) && !sat;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(RATIO_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      total_r <= req.total;
      dvs_r   <= req.divisor;
      zero_r  <= (req.divisor == '0);
      // upper part of the numerator is below the divisor once sat is clear
      rem_r   <= req.total[PT_W+7:8];
      num_r   <= {req.total[7:0], 16'b0};
      if (req.divisor == '0) begin
        quo_r <= '0;
      end else if (sat) begin
        quo_r <= '1;
      end else begin
        quo_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= qbit ? diff[PT_W-1:0] : trial[PT_W-1:0];
      num_r <= {num_r[RATIO_W-2:0], 1'b0};
      quo_r <= {quo_r[RATIO_W-2:0], qbit};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.ratio    = quo_r;
  assign rsp.pt_total = total_r;
  assign rsp.zero_pt  = zero_r;

endmodule

`default_nettype wire
